### src/positional_deque_store_defines.svh
// ----------------------------------------------------------------------------
// positional deque store assertion macros
// shared concurrent assertion forms, clocked on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_DEQUE_STORE_DEFINES_SVH
`define POSITIONAL_DEQUE_STORE_DEFINES_SVH

// condition holds at every edge out of reset
`define PDS_ASSERT_ALWAYS(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("pds: invariant violated");

// antecedent at one edge implies consequent at the next
`define PDS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pds: sequence violated");

`endif

### src/pds_pkg.sv
// ----------------------------------------------------------------------------
// pds_pkg
// shared types and codes of the positional deque store
// ----------------------------------------------------------------------------
package pds_pkg;

  localparam int POS_W   = 5;
  localparam int COUNT_W = 5;

  // command codes on the command port
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_INSERT     = 3'd2;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [2:0] CMD_POP_BACK   = 3'd4;
  localparam logic [2:0] CMD_ERASE      = 3'd5;
  localparam logic [2:0] CMD_DUMP       = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  typedef enum logic [2:0] {
    OP_ADD_FRONT,
    OP_ADD_BACK,
    OP_ADD_AT,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_ERASE,
    OP_DUMP,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic [31:0]        name_tag;
    logic signed [15:0] hp;
    logic signed [15:0] damage;
    logic signed [15:0] speed;
  } record_t;

  typedef struct packed {
    op_t              op;
    logic [POS_W-1:0] position;
    record_t          rec;
  } req_t;

endpackage

### src/pds_front.sv
// ----------------------------------------------------------------------------
// pds_front
// command intake: handshake and decode of the command code into an operation
// ----------------------------------------------------------------------------
module pds_front import pds_pkg::*; (
  input  logic               start,
  input  logic [2:0]         command,
  input  logic [POS_W-1:0]   position,
  input  logic [31:0]        name_tag,
  input  logic signed [15:0] hp,
  input  logic signed [15:0] damage,
  input  logic signed [15:0] speed,
  input  logic               q_full,
  output logic               busy,
  output logic               q_push,
  output req_t               q_wdata
);

  op_t op;

  always_comb begin
    case (command)
      CMD_PUSH_FRONT: op = OP_ADD_FRONT;
      CMD_PUSH_BACK:  op = OP_ADD_BACK;
      CMD_INSERT:     op = OP_ADD_AT;
      CMD_POP_FRONT:  op = OP_POP_FRONT;
      CMD_POP_BACK:   op = OP_POP_BACK;
      CMD_ERASE:      op = OP_ERASE;
      CMD_DUMP:       op = OP_DUMP;
      default:        op = OP_NOP;
    endcase
  end

  // stall only while the queue holds no free slot
  assign busy   = q_full;
  assign q_push = start && !q_full;

  always_comb begin
    q_wdata.op           = op;
    q_wdata.position     = position;
    q_wdata.rec.name_tag = name_tag;
    q_wdata.rec.hp       = hp;
    q_wdata.rec.damage   = damage;
    q_wdata.rec.speed    = speed;
  end

endmodule

### src/pds_queue.sv
// ----------------------------------------------------------------------------
// pds_queue
// two-entry command queue between intake and execution
// ----------------------------------------------------------------------------
module pds_queue import pds_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t wdata,
  input  logic pop,
  output req_t rdata,
  output logic valid,
  output logic full
);

  req_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] level;

  assign valid = (level != 2'd0);
  assign full  = (level == 2'd2);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) level <= level + 2'd1;
      else if (pop && !push) level <= level - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wdata;
  end

endmodule

### src/pds_back.sv
// ----------------------------------------------------------------------------
// pds_back
// execution: row of record cells, count, dump sequencing, result register
// ----------------------------------------------------------------------------
`include "positional_deque_store_defines.svh"

module pds_back import pds_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  req_t                 req,
  input  logic                 req_valid,
  output logic                 req_pop,
  output logic                 result_valid,
  output logic [1:0]           status,
  output logic [COUNT_W-1:0]   count,
  output logic                 store_empty,
  output logic                 item_valid,
  output logic [31:0]          item_name_tag,
  output logic signed [15:0]   item_hp,
  output logic signed [15:0]   item_damage,
  output logic signed [15:0]   item_speed,
  output logic                 last
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = $clog2(DEPTH);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  record_t         cells [DEPTH];
  logic [CW-1:0]   cnt;
  logic [CW-1:0]   cnt_next;
  logic            dumping;
  logic            dumping_next;
  logic [IW-1:0]   di;
  logic [IW-1:0]   di_next;
  logic [IW-1:0]   rd_idx;
  logic [CMPW-1:0] cnt_ext;
  logic [CMPW-1:0] cnt_next_ext;
  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] add_pos;
  logic [CMPW-1:0] rm_pos;
  logic            add_req;
  logic            do_add;
  logic            do_rm;
  logic            emit;
  logic            emit_item;
  logic            emit_last;
  logic [1:0]      st;

  assign cnt_ext      = CMPW'(cnt);
  assign cnt_next_ext = CMPW'(cnt_next);
  assign pos_ext      = CMPW'(req.position);
  assign req_pop      = req_valid && !dumping;

  always_comb begin
    cnt_next     = cnt;
    dumping_next = dumping;
    di_next      = di;
    rd_idx       = di;
    add_req      = 1'b0;
    add_pos      = '0;
    do_add       = 1'b0;
    do_rm        = 1'b0;
    rm_pos       = '0;
    emit         = 1'b0;
    emit_item    = 1'b0;
    emit_last    = 1'b1;
    st           = ST_OK;
    if (dumping) begin
      emit         = 1'b1;
      emit_item    = 1'b1;
      emit_last    = (CMPW'(di) + CMPW'(1)) == cnt_ext;
      dumping_next = !emit_last;
      di_next      = di + IW'(1);
    end else if (req_valid) begin
      emit = 1'b1;
      case (req.op)
        OP_ADD_FRONT: begin
          add_req = 1'b1;
          add_pos = '0;
        end
        OP_ADD_BACK: begin
          add_req = 1'b1;
          add_pos = cnt_ext;
        end
        OP_ADD_AT: begin
          add_req = 1'b1;
          add_pos = pos_ext;
        end
        OP_POP_FRONT: begin
          if (cnt == '0) st = ST_EMPTY;
          else begin
            do_rm    = 1'b1;
            rm_pos   = '0;
            cnt_next = cnt - CW'(1);
          end
        end
        OP_POP_BACK: begin
          if (cnt == '0) st = ST_EMPTY;
          else cnt_next = cnt - CW'(1);
        end
        OP_ERASE: begin
          if (pos_ext >= cnt_ext) st = ST_BADPOS;
          else begin
            do_rm    = 1'b1;
            rm_pos   = pos_ext;
            cnt_next = cnt - CW'(1);
          end
        end
        OP_DUMP: begin
          if (cnt == '0) st = ST_EMPTY;
          else begin
            // first record leaves now, the rest follow one a cycle
            emit_item    = 1'b1;
            rd_idx       = '0;
            emit_last    = (cnt_ext == CMPW'(1));
            dumping_next = !emit_last;
            di_next      = IW'(1);
          end
        end
        default: ;
      endcase
      if (add_req) begin
        // position is checked before fullness
        if (add_pos > cnt_ext) st = ST_BADPOS;
        else if (cnt_ext == CMPW'(DEPTH)) st = ST_FULL;
        else begin
          do_add   = 1'b1;
          cnt_next = cnt + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      dumping      <= 1'b0;
      di           <= '0;
      result_valid <= 1'b0;
    end else begin
      cnt          <= cnt_next;
      dumping      <= dumping_next;
      di           <= di_next;
      result_valid <= emit;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    status      <= st;
    count       <= cnt_next_ext[COUNT_W-1:0];
    store_empty <= (cnt_next == '0);
    item_valid  <= emit_item;
    last        <= emit_last;
    if (emit_item) begin
      item_name_tag <= cells[rd_idx].name_tag;
      item_hp       <= cells[rd_idx].hp;
      item_damage   <= cells[rd_idx].damage;
      item_speed    <= cells[rd_idx].speed;
    end else begin
      item_name_tag <= '0;
      item_hp       <= '0;
      item_damage   <= '0;
      item_speed    <= '0;
    end
  end

  // cell row: each cell loads new data, its lower or its upper neighbor
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (do_add && CMPW'(i) == add_pos) cells[i] <= req.rec;
    end
    for (int i = 1; i < DEPTH; i++) begin
      if (do_add && CMPW'(i) > add_pos) cells[i] <= cells[i-1];
    end
    for (int i = 0; i < DEPTH - 1; i++) begin
      if (do_rm && CMPW'(i) >= rm_pos) cells[i] <= cells[i+1];
    end
  end

  `PDS_ASSERT_ALWAYS(a_count_bound, cnt_ext <= CMPW'(DEPTH))
  `PDS_ASSERT_NEXT(a_dump_burst, result_valid && !last, result_valid && item_valid)
  `PDS_ASSERT_ALWAYS(a_item_ok, !(result_valid && item_valid) || status == ST_OK)
  `PDS_ASSERT_ALWAYS(a_no_pop_in_dump, !(dumping && req_pop))

endmodule

### src/positional_deque_store.sv
// ----------------------------------------------------------------------------
// positional_deque_store
// a command is written to a queue slot, and its first result word to the result register
// one command per cycle while busy is low; a dump holds execution to its last word
// busy rises only while the two-entry command queue is full (during a long dump)
// reset: synchronous, empties the store and queue; record cells are not cleared
// ----------------------------------------------------------------------------
module positional_deque_store import pds_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           command,
  input  logic [POS_W-1:0]     position,
  input  logic [31:0]          name_tag,
  input  logic signed [15:0]   hp,
  input  logic signed [15:0]   damage,
  input  logic signed [15:0]   speed,
  output logic                 result_valid,
  output logic [1:0]           status,
  output logic [COUNT_W-1:0]   count,
  output logic                 store_empty,
  output logic                 item_valid,
  output logic [31:0]          item_name_tag,
  output logic signed [15:0]   item_hp,
  output logic signed [15:0]   item_damage,
  output logic signed [15:0]   item_speed,
  output logic                 last
);

  // front to queue
  logic q_push;
  req_t q_wdata;
  logic q_full;
  // queue to back
  req_t q_rdata;
  logic q_valid;
  logic q_pop;

  // intake decodes the command word into an operation; it never needs store state
  pds_front u_front (
    .start    (start),
    .command  (command),
    .position (position),
    .name_tag (name_tag),
    .hp       (hp),
    .damage   (damage),
    .speed    (speed),
    .q_full   (q_full),
    .busy     (busy),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  // short queue lets intake keep taking words while a dump streams out
  pds_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .valid (q_valid),
    .full  (q_full)
  );

  // execution: all range and fullness checks, a parallel shift of the cell row,
  // one result word per cycle through the output register
  pds_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .req           (q_rdata),
    .req_valid     (q_valid),
    .req_pop       (q_pop),
    .result_valid  (result_valid),
    .status        (status),
    .count         (count),
    .store_empty   (store_empty),
    .item_valid    (item_valid),
    .item_name_tag (item_name_tag),
    .item_hp       (item_hp),
    .item_damage   (item_damage),
    .item_speed    (item_speed),
    .last          (last)
  );

endmodule

### tb/sv/tb_positional_deque_store.sv
// ----------------------------------------------------------------------------
// tb_positional_deque_store
// drives commands into the deque store and checks every result word against
// a shadow copy of the records kept in a small scoreboard class; a directed
// opening covers the empty, bad-position and full cases and the field
// extremes; three random phases follow, each with its own sender gap rate,
// and the sender waits for every expected result word between phases
// ----------------------------------------------------------------------------
module tb_positional_deque_store;
  import pds_pkg::*;

  localparam int DEPTH = 16;

  // one result word as the block presents it
  typedef struct packed {
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
    logic               store_empty;
    logic               item_valid;
    record_t            rec;
    logic               last;
  } result_word_t;

  // shadow of the store: predicts the result words of every accepted command
  // and checks the words that come back, oldest first
  class deque_shadow;
    record_t      slots [DEPTH];
    int           held;
    result_word_t pending_words [$];
    int           mismatches;
    int           commands;
    int           words_checked;
    int           full_hits;
    int           badpos_hits;
    int           empty_hits;

    function int pending_count();
      return pending_words.size();
    endfunction

    task flag_mismatch(string what);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] error: %s", $time, what);
    endtask

    function void queue_word(logic [1:0] st, int slot, bit fin);
      result_word_t w;
      w.status      = st;
      w.count       = COUNT_W'(held);
      w.store_empty = (held == 0);
      w.item_valid  = (slot >= 0);
      w.rec         = (slot >= 0) ? slots[slot] : '0;
      w.last        = fin;
      pending_words.insert(pending_words.size(), w);
      if (st == ST_FULL) full_hits++;
      if (st == ST_BADPOS) badpos_hits++;
      if (st == ST_EMPTY) empty_hits++;
    endfunction

    // position is checked before fullness
    function logic [1:0] add_record(int at, record_t rec);
      if (at > held) return ST_BADPOS;
      if (held >= DEPTH) return ST_FULL;
      for (int i = held; i > at; i--) slots[i] = slots[i-1];
      slots[at] = rec;
      held++;
      return ST_OK;
    endfunction

    function void drop_record(int at);
      for (int i = at; i + 1 < held; i++) slots[i] = slots[i+1];
      held--;
    endfunction

    function void note_command(logic [2:0] cmd, logic [POS_W-1:0] pos, record_t rec);
      logic [1:0] st;
      st = ST_OK;
      commands++;
      case (cmd)
        CMD_PUSH_FRONT: st = add_record(0, rec);
        CMD_PUSH_BACK:  st = add_record(held, rec);
        CMD_INSERT:     st = add_record(int'(pos), rec);
        CMD_POP_FRONT: begin
          if (held == 0) st = ST_EMPTY;
          else drop_record(0);
        end
        CMD_POP_BACK: begin
          if (held == 0) st = ST_EMPTY;
          else held--;
        end
        CMD_ERASE: begin
          if (int'(pos) >= held) st = ST_BADPOS;
          else drop_record(int'(pos));
        end
        CMD_DUMP: begin
          if (held == 0) queue_word(ST_EMPTY, -1, 1'b1);
          else for (int i = 0; i < held; i++) queue_word(ST_OK, i, i == held - 1);
          return;
        end
        default: ;
      endcase
      queue_word(st, -1, 1'b1);
    endfunction

    task check_word(result_word_t got);
      result_word_t want;
      words_checked++;
      if (pending_words.size() == 0) begin
        flag_mismatch($sformatf("result word with nothing expected, status %0d count %0d",
                                got.status, got.count));
        return;
      end
      want = pending_words[0];
      pending_words.delete(0);
      if (got.status !== want.status)
        flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.count !== want.count)
        flag_mismatch($sformatf("count %0d, want %0d", got.count, want.count));
      if (got.store_empty !== want.store_empty)
        flag_mismatch($sformatf("store_empty %b, want %b",
                                got.store_empty, want.store_empty));
      if (got.item_valid !== want.item_valid)
        flag_mismatch($sformatf("item_valid %b, want %b", got.item_valid, want.item_valid));
      if (got.rec.name_tag !== want.rec.name_tag)
        flag_mismatch($sformatf("item_name_tag %h, want %h",
                                got.rec.name_tag, want.rec.name_tag));
      if (got.rec.hp !== want.rec.hp)
        flag_mismatch($sformatf("item_hp %0d, want %0d", got.rec.hp, want.rec.hp));
      if (got.rec.damage !== want.rec.damage)
        flag_mismatch($sformatf("item_damage %0d, want %0d",
                                got.rec.damage, want.rec.damage));
      if (got.rec.speed !== want.rec.speed)
        flag_mismatch($sformatf("item_speed %0d, want %0d", got.rec.speed, want.rec.speed));
      if (got.last !== want.last)
        flag_mismatch($sformatf("last %b, want %b", got.last, want.last));
    endtask
  endclass

  // clock, reset and block inputs, all known from time zero
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [2:0]          command = CMD_PUSH_FRONT;
  logic [POS_W-1:0]    position = '0;
  logic [31:0]         name_tag = '0;
  logic signed [15:0]  hp = '0;
  logic signed [15:0]  damage = '0;
  logic signed [15:0]  speed = '0;

  logic                busy;
  logic                result_valid;
  logic [1:0]          status;
  logic [COUNT_W-1:0]  count;
  logic                store_empty;
  logic                item_valid;
  logic [31:0]         item_name_tag;
  logic signed [15:0]  item_hp;
  logic signed [15:0]  item_damage;
  logic signed [15:0]  item_speed;
  logic                last;

  deque_shadow  shadow = new;
  result_word_t observed;

  always #6 clk = ~clk;

  positional_deque_store #(.DEPTH(DEPTH)) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .position(position),
    .name_tag(name_tag),
    .hp(hp),
    .damage(damage),
    .speed(speed),
    .result_valid(result_valid),
    .status(status),
    .count(count),
    .store_empty(store_empty),
    .item_valid(item_valid),
    .item_name_tag(item_name_tag),
    .item_hp(item_hp),
    .item_damage(item_damage),
    .item_speed(item_speed),
    .last(last)
  );

  // one sampling point per rising edge: a result word on the ports is checked,
  // then a command taken at this edge is noted; each command passes a queue
  // slot and the result register, so no word belongs to the command just taken
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) begin
        observed = {status, count, store_empty, item_valid,
                    item_name_tag, item_hp, item_damage, item_speed, last};
        shadow.check_word(observed);
      end
      if (start && !busy) shadow.note_command(command, position, {name_tag, hp, damage, speed});
    end
  end

  // half random values, half the extremes, zero and minus one
  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic record_t random_record();
    record_t rec;
    case ($urandom_range(5))
      0: rec.name_tag = 32'h0000_0000;
      1: rec.name_tag = 32'hffff_ffff;
      default: rec.name_tag = $urandom;
    endcase
    rec.hp     = pick_value();
    rec.damage = pick_value();
    rec.speed  = pick_value();
    return rec;
  endfunction

  // called at a falling edge; holds start and the word until the block takes
  // it, and returns at the next falling edge with start still high
  task automatic send_command(logic [2:0] cmd, logic [POS_W-1:0] pos, record_t rec);
    start    <= 1'b1;
    command  <= cmd;
    position <= pos;
    name_tag <= rec.name_tag;
    hp       <= rec.hp;
    damage   <= rec.damage;
    speed    <= rec.speed;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic hold_off(int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // sender stays quiet until every predicted word has come back
  task automatic wait_drained();
    start <= 1'b0;
    while (shadow.pending_count() != 0) @(negedge clk);
  endtask

  // random commands; grow_pct and shrink_pct steer the fill level, dumps take
  // a tenth and the remainder goes to the unused command code; positions are
  // mostly legal for the current fill, sometimes anything in 0..16
  task automatic run_phase(int items, int idle_pct, int grow_pct, int shrink_pct);
    for (int n = 0; n < items; n++) begin
      logic [2:0]       cmd;
      logic [POS_W-1:0] pos;
      int               roll;
      int               fill;
      // each cycle the sender idles with probability idle_pct in a hundred
      while ($urandom_range(99) < idle_pct) hold_off(1);
      roll = $urandom_range(99);
      fill = shadow.held;
      pos  = POS_W'($urandom_range(16, 0));
      if (roll < grow_pct) begin
        case ($urandom_range(2))
          0: cmd = CMD_PUSH_FRONT;
          1: cmd = CMD_PUSH_BACK;
          default: begin
            cmd = CMD_INSERT;
            if ($urandom_range(9) != 0) pos = POS_W'($urandom_range(fill, 0));
          end
        endcase
      end else if (roll < grow_pct + shrink_pct) begin
        case ($urandom_range(2))
          0: cmd = CMD_POP_FRONT;
          1: cmd = CMD_POP_BACK;
          default: begin
            cmd = CMD_ERASE;
            if (fill > 0 && $urandom_range(9) != 0)
              pos = POS_W'($urandom_range(fill - 1, 0));
          end
        endcase
      end else if (roll < grow_pct + shrink_pct + 10) begin
        cmd = CMD_DUMP;
      end else begin
        cmd = OP_NOP;
      end
      send_command(cmd, pos, random_record());
    end
  endtask

  initial begin
    record_t          rec;
    logic [2:0]       cmd;
    logic [POS_W-1:0] pos;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // everything that can go wrong on an empty store
    send_command(CMD_DUMP, 5'd0, random_record());
    send_command(CMD_POP_FRONT, 5'd0, random_record());
    send_command(CMD_POP_BACK, 5'd0, random_record());
    send_command(CMD_ERASE, 5'd0, random_record());
    send_command(CMD_INSERT, 5'd1, random_record());
    send_command(OP_NOP, 5'd0, random_record());

    // fill to the brim through all three add paths, the first two records
    // carrying the field extremes; inserts hit the back end and the front
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) rec = record_t'{32'h0000_0000, 16'sh8000, 16'sh7fff, 16'sh0000};
      else if (i == 1) rec = record_t'{32'hffff_ffff, 16'sh7fff, 16'sh8000, -16'sd1};
      else rec = random_record();
      case (i % 3)
        0: begin
          cmd = CMD_PUSH_BACK;
          pos = 5'd0;
        end
        1: begin
          cmd = CMD_PUSH_FRONT;
          pos = 5'd0;
        end
        default: begin
          cmd = CMD_INSERT;
          if (i == 2) pos = POS_W'(shadow.held);
          else if (i == 5) pos = 5'd0;
          else pos = POS_W'($urandom_range(shadow.held, 0));
        end
      endcase
      send_command(cmd, pos, rec);
    end

    // full store: refused adds, a sixteen-word dump, erase past and at the end
    send_command(CMD_PUSH_BACK, 5'd0, random_record());
    send_command(CMD_INSERT, 5'd16, random_record());
    send_command(CMD_DUMP, 5'd0, random_record());
    send_command(CMD_ERASE, 5'd16, random_record());
    send_command(CMD_ERASE, 5'd15, random_record());
    send_command(CMD_POP_FRONT, 5'd0, random_record());
    send_command(CMD_POP_BACK, 5'd0, random_record());
    wait_drained();

    // light gaps and a filling trend, then heavy gaps while draining,
    // then back-to-back commands around the middle
    run_phase(40, 17, 58, 30);
    wait_drained();
    run_phase(40, 85, 30, 55);
    wait_drained();
    run_phase(40, 0, 45, 40);
    wait_drained();

    // idle on to catch any stray word after the last expected one
    repeat (20) @(negedge clk);

    if (shadow.pending_count() != 0)
      shadow.flag_mismatch($sformatf("%0d result words never arrived", shadow.pending_count()));
    $display("covered %0d commands, %0d result words",
             shadow.commands, shadow.words_checked);
    $display("%0d refused full, %0d bad positions, %0d on empty; light, heavy and no gaps",
             shadow.full_hits, shadow.badpos_hits, shadow.empty_hits);
    if (shadow.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
